// ===== src/bcg_pkg.sv =====
`timescale 1ns / 1ps

package bcg_pkg;

   localparam int DEF_QUAL_LEVELS  = 64;
   localparam int DEF_DIMER_LEVELS = 25;
   localparam int DEF_GC_LEVELS    = 16;
   localparam int DEF_RUN_LEVELS   = 32;
   localparam int DEF_MAXQ_LEVELS  = 64;
   localparam int DEF_READ_LEVELS  = 64;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int WLEN_W     = 4;
   localparam int GC_W       = 4;

   localparam logic [0:0] REG_GC_WINDOW_LEN = 1'b0;

   localparam logic [1:0] CMD_START = 2'd0;
   localparam logic [1:0] CMD_SCAN  = 2'd1;
   localparam logic [1:0] CMD_BASE  = 2'd2;

   localparam logic [1:0] CASE_SAME = 2'd0;
   localparam logic [1:0] CASE_DIFF = 2'd1;
   localparam logic [1:0] CASE_SKIP = 2'd2;

   localparam logic [7:0] CHAR_A = 8'h41;
   localparam logic [7:0] CHAR_C = 8'h43;
   localparam logic [7:0] CHAR_G = 8'h47;
   localparam logic [7:0] CHAR_T = 8'h54;
   localparam logic [7:0] CHAR_N = 8'h4E;

   localparam logic [2:0] CODE_A     = 3'd0;
   localparam logic [2:0] CODE_C     = 3'd1;
   localparam logic [2:0] CODE_G     = 3'd2;
   localparam logic [2:0] CODE_T     = 3'd3;
   localparam logic [2:0] CODE_OTHER = 3'd4;

   typedef struct packed {
      logic [31:0]     position;
      logic [31:0]     offset;
      logic [7:0]      read_num;
      logic [2:0]      prev_code;
      logic [2:0]      cur_code;
      logic [GC_W-1:0] gc;
      logic [7:0]      run;
      logic [7:0]      maxq;
      logic [7:0]      qual;
      logic            mismatch;
   } bcg_item_type;

   function automatic logic [2:0] base_code(input logic [7:0] ch);
      logic [2:0] code;
      unique case (ch)
         CHAR_A:  code = CODE_A;
         CHAR_C:  code = CODE_C;
         CHAR_G:  code = CODE_G;
         CHAR_T:  code = CODE_T;
         default: code = CODE_OTHER;
      endcase
      return code;
   endfunction

endpackage

// ===== src/bcg_front.sv =====
`timescale 1ns / 1ps

module bcg_front #(
   parameter int GC_LEVELS = bcg_pkg::DEF_GC_LEVELS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push,
   input  logic                            queue_full,
   input  logic [1:0]                      req_cmd,
   input  logic [7:0]                      req_base_char,
   input  logic [7:0]                      req_quality,
   input  logic [1:0]                      req_case_here,
   input  logic [1:0]                      req_case_next,
   input  logic [7:0]                      req_read_number,
   input  logic [31:0]                     req_position_offset,
   input  logic                            req_reverse_order,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [bcg_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [bcg_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [bcg_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            queue_push,
   output bcg_pkg::bcg_item_type           queue_item
);
   import bcg_pkg::*;

   localparam int HIST_W = GC_LEVELS - 1;

   logic [WLEN_W-1:0] wlen_ff, wlen_in;
   logic [7:0]        prev_base_ff, prev_base_in;
   logic [7:0]        run_ff, run_in;
   logic [HIST_W-1:0] hist_ff, hist_in;
   logic [31:0]       pos_ff, pos_in;
   logic [7:0]        maxq_ff, maxq_in;
   logic [7:0]        read_ff, read_in;
   logic [31:0]       offset_ff, offset_in;
   logic              rev_ff, rev_in;
   logic [1:0]        prev_case_ff, prev_case_in;

   logic              accept;
   logic              csr_write;
   logic [WLEN_W:0]   wlen_eff;
   logic [HIST_W-1:0] win_mask;
   logic [GC_W-1:0]   gc_now;
   logic [1:0]        counted;
   logic              is_gc;

   assign accept    = push && !queue_full;
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      wlen_in = wlen_ff;
      if (csr_write && paddr[CSR_ADDR_W-1:2] == REG_GC_WINDOW_LEN) begin
         wlen_in = pwdata[WLEN_W-1:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[CSR_ADDR_W-1:2] == REG_GC_WINDOW_LEN) begin
         prdata = CSR_DATA_W'(wlen_ff);
      end
   end

   // g/c window over kept history
   always_comb begin
      wlen_eff = ({1'b0, wlen_ff} >= (WLEN_W + 1)'(GC_LEVELS))
               ? (WLEN_W + 1)'(GC_LEVELS - 1) : {1'b0, wlen_ff};
      for (int i = 0; i < HIST_W; i++) begin
         win_mask[i] = (WLEN_W + 1)'(i) < wlen_eff;
      end
      gc_now = GC_W'($countones(hist_ff & win_mask));
   end

   assign is_gc   = (req_base_char == CHAR_G) || (req_base_char == CHAR_C);
   assign counted = rev_ff ? prev_case_ff : req_case_next;

   always_comb begin
      prev_base_in = prev_base_ff;
      run_in       = run_ff;
      hist_in      = hist_ff;
      pos_in       = pos_ff;
      maxq_in      = maxq_ff;
      read_in      = read_ff;
      offset_in    = offset_ff;
      rev_in       = rev_ff;
      prev_case_in = prev_case_ff;
      queue_push   = 1'b0;

      if (req_base_char == prev_base_ff) begin
         queue_item.run = (run_ff == 8'hFF) ? run_ff : run_ff + 8'd1;
      end else begin
         queue_item.run = '0;
      end
      queue_item.position  = pos_ff;
      queue_item.offset    = offset_ff;
      queue_item.read_num  = read_ff;
      queue_item.prev_code = base_code(prev_base_ff);
      queue_item.cur_code  = base_code(req_base_char);
      queue_item.gc        = gc_now;
      queue_item.maxq      = maxq_ff;
      queue_item.qual      = req_quality;
      queue_item.mismatch  = (counted == CASE_DIFF);

      if (accept) begin
         unique case (req_cmd)
            CMD_START: begin
               prev_base_in = CHAR_N;
               run_in       = '0;
               hist_in      = '0;
               pos_in       = '0;
               maxq_in      = '0;
               prev_case_in = CASE_SAME;
               read_in      = req_read_number;
               offset_in    = req_position_offset;
               rev_in       = req_reverse_order;
            end
            CMD_SCAN: begin
               if (req_quality > maxq_ff) begin
                  maxq_in = req_quality;
               end
            end
            CMD_BASE: begin
               run_in       = queue_item.run;
               hist_in      = HIST_W'({hist_ff, is_gc});
               prev_case_in = req_case_here;
               prev_base_in = req_base_char;
               pos_in       = pos_ff + 32'd1;
               queue_push   = (req_case_here != CASE_SKIP) && (req_case_next != CASE_SKIP)
                            && ((counted == CASE_SAME) || (counted == CASE_DIFF));
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wlen_ff      <= '0;
         prev_base_ff <= CHAR_N;
         run_ff       <= '0;
         hist_ff      <= '0;
         pos_ff       <= '0;
         maxq_ff      <= '0;
         read_ff      <= '0;
         offset_ff    <= '0;
         rev_ff       <= 1'b0;
         prev_case_ff <= CASE_SAME;
      end else begin
         wlen_ff      <= wlen_in;
         prev_base_ff <= prev_base_in;
         run_ff       <= run_in;
         hist_ff      <= hist_in;
         pos_ff       <= pos_in;
         maxq_ff      <= maxq_in;
         read_ff      <= read_in;
         offset_ff    <= offset_in;
         rev_ff       <= rev_in;
         prev_case_ff <= prev_case_in;
      end
   end

endmodule

// ===== src/bcg_queue.sv =====
`timescale 1ns / 1ps

module bcg_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_en,
   input  bcg_pkg::bcg_item_type wr_item,
   input  logic                  rd_en,
   output bcg_pkg::bcg_item_type rd_item,
   output logic                  full,
   output logic                  empty
);
   import bcg_pkg::*;

   bcg_item_type               slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_W:0]       count_ff, count_in;
   logic                       do_wr, do_rd;

   assign full    = (count_ff == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_item = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_wr ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== src/bcg_back.sv =====
`timescale 1ns / 1ps

module bcg_back #(
   parameter int QUAL_LEVELS  = bcg_pkg::DEF_QUAL_LEVELS,
   parameter int DIMER_LEVELS = bcg_pkg::DEF_DIMER_LEVELS,
   parameter int RUN_LEVELS   = bcg_pkg::DEF_RUN_LEVELS,
   parameter int MAXQ_LEVELS  = bcg_pkg::DEF_MAXQ_LEVELS,
   parameter int READ_LEVELS  = bcg_pkg::DEF_READ_LEVELS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  queue_empty,
   input  bcg_pkg::bcg_item_type queue_item,
   output logic                  queue_pop,
   input  logic                  pop,
   output logic                  empty,
   output logic [63:0]           rsp_covariate_key,
   output logic                  rsp_is_mismatch
);
   import bcg_pkg::*;

   logic        valid_ff, valid_in;
   logic [63:0] key_ff, key_in;
   logic        mis_ff, mis_in;

   logic [31:0] cycle;
   logic [4:0]  dimer;
   logic [7:0]  read_c, run_c, maxq_c, qual_c;
   logic [4:0]  dimer_c;

   assign empty             = !valid_ff;
   assign rsp_covariate_key = key_ff;
   assign rsp_is_mismatch   = mis_ff;
   assign queue_pop         = !queue_empty && (!valid_ff || pop);

   always_comb begin
      cycle   = queue_item.position + queue_item.offset;
      dimer   = {queue_item.prev_code, 2'b00} + 5'(queue_item.prev_code)
              + 5'(queue_item.cur_code);
      read_c  = (queue_item.read_num >= 8'(READ_LEVELS)) ? 8'(READ_LEVELS - 1)
              : queue_item.read_num;
      dimer_c = (dimer >= 5'(DIMER_LEVELS)) ? 5'(DIMER_LEVELS - 1) : dimer;
      run_c   = (queue_item.run >= 8'(RUN_LEVELS)) ? 8'(RUN_LEVELS - 1) : queue_item.run;
      maxq_c  = (queue_item.maxq >= 8'(MAXQ_LEVELS)) ? 8'(MAXQ_LEVELS - 1)
              : queue_item.maxq;
      qual_c  = (queue_item.qual >= 8'(QUAL_LEVELS)) ? 8'(QUAL_LEVELS - 1)
              : queue_item.qual;
      key_in  = key_ff;
      mis_in  = mis_ff;
      if (queue_pop) begin
         key_in = {cycle, read_c[5:0], dimer_c, queue_item.gc, run_c[4:0],
                   maxq_c[5:0], qual_c[5:0]};
         mis_in = queue_item.mismatch;
      end
      valid_in = queue_pop || (valid_ff && !pop);
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      mis_ff <= mis_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

endmodule

// ===== src/base_covariate_key_generator_unit.sv =====
`timescale 1ns / 1ps

// covariate key generator for base quality recalibration. a read is fed as one
// start request, then quality scan requests, then one base request per base;
// each counted base gives one 64-bit key (cycle, read, dimer, gc, run, max
// quality, quality) and a mismatch flag. one request is taken every cycle while
// full is low: the front holds the per-read history and updates it, a four-entry
// queue carries counted bases to the back, which adds the cycle offset, clamps the
// fields and holds the key in an output register. a key passes through a queue
// slot and then the output register before it is on the result side.
// full rises only when the queue is full and the result side is stalled.
// gc_window_len sits at byte address 0 and should be written while idle.

module base_covariate_key_generator_unit #(
   parameter int QUAL_LEVELS  = bcg_pkg::DEF_QUAL_LEVELS,
   parameter int DIMER_LEVELS = bcg_pkg::DEF_DIMER_LEVELS,
   parameter int GC_LEVELS    = bcg_pkg::DEF_GC_LEVELS,
   parameter int RUN_LEVELS   = bcg_pkg::DEF_RUN_LEVELS,
   parameter int MAXQ_LEVELS  = bcg_pkg::DEF_MAXQ_LEVELS,
   parameter int READ_LEVELS  = bcg_pkg::DEF_READ_LEVELS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push,
   output logic                            full,
   input  logic [1:0]                      req_cmd,
   input  logic [7:0]                      req_base_char,
   input  logic [7:0]                      req_quality,
   input  logic [1:0]                      req_case_here,
   input  logic [1:0]                      req_case_next,
   input  logic [7:0]                      req_read_number,
   input  logic [31:0]                     req_position_offset,
   input  logic                            req_reverse_order,
   output logic                            empty,
   input  logic                            pop,
   output logic [63:0]                     rsp_covariate_key,
   output logic                            rsp_is_mismatch,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [bcg_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [bcg_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [bcg_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready
);
   import bcg_pkg::*;

   logic         q_push, q_pop, q_full, q_empty;
   bcg_item_type q_wr_item, q_rd_item;

   assign full   = q_full;
   assign pready = 1'b1;

   bcg_front #(
      .GC_LEVELS (GC_LEVELS)
   ) u_front (
      .clock               (clock),
      .reset               (reset),
      .push                (push),
      .queue_full          (q_full),
      .req_cmd             (req_cmd),
      .req_base_char       (req_base_char),
      .req_quality         (req_quality),
      .req_case_here       (req_case_here),
      .req_case_next       (req_case_next),
      .req_read_number     (req_read_number),
      .req_position_offset (req_position_offset),
      .req_reverse_order   (req_reverse_order),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .prdata              (prdata),
      .queue_push          (q_push),
      .queue_item          (q_wr_item)
   );

   bcg_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (q_push),
      .wr_item (q_wr_item),
      .rd_en   (q_pop),
      .rd_item (q_rd_item),
      .full    (q_full),
      .empty   (q_empty)
   );

   bcg_back #(
      .QUAL_LEVELS  (QUAL_LEVELS),
      .DIMER_LEVELS (DIMER_LEVELS),
      .RUN_LEVELS   (RUN_LEVELS),
      .MAXQ_LEVELS  (MAXQ_LEVELS),
      .READ_LEVELS  (READ_LEVELS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .queue_empty       (q_empty),
      .queue_item        (q_rd_item),
      .queue_pop         (q_pop),
      .pop               (pop),
      .empty             (empty),
      .rsp_covariate_key (rsp_covariate_key),
      .rsp_is_mismatch   (rsp_is_mismatch)
   );

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import bcg_pkg::*;

   localparam logic [1:0] CMD_UNUSED    = 2'd3;
   localparam logic [1:0] CASE_RESERVED = 2'd3;
   localparam int         CYCLE_LIMIT   = 400_000;
   localparam int         ITEM_TARGET   = 1250;
   localparam int         SETTLE_CYCLES = 8;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [7:0]  base_char;
      logic [7:0]  quality;
      logic [1:0]  case_here;
      logic [1:0]  case_next;
      logic [7:0]  read_number;
      logic [31:0] position_offset;
      logic        reverse_order;
   } base_request_type;

   typedef struct packed {
      logic [63:0] key;
      logic        mismatch;
   } key_result_type;

   typedef struct packed {
      base_request_type req;
      logic             known;
      key_result_type   want;
   } stim_row_type;

   localparam key_result_type NO_RESULT = '0;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   logic [1:0]  req_cmd = CMD_START;
   logic [7:0]  req_base_char = 8'd0;
   logic [7:0]  req_quality = 8'd0;
   logic [1:0]  req_case_here = CASE_SAME;
   logic [1:0]  req_case_next = CASE_SAME;
   logic [7:0]  req_read_number = 8'd0;
   logic [31:0] req_position_offset = 32'd0;
   logic        req_reverse_order = 1'b0;
   logic        empty;
   logic        pop = 1'b0;
   logic [63:0] rsp_covariate_key;
   logic        rsp_is_mismatch;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic        pready;

   base_covariate_key_generator_unit u_dut (
      .clock               (clock),
      .reset               (reset),
      .push                (push),
      .full                (full),
      .req_cmd             (req_cmd),
      .req_base_char       (req_base_char),
      .req_quality         (req_quality),
      .req_case_here       (req_case_here),
      .req_case_next       (req_case_next),
      .req_read_number     (req_read_number),
      .req_position_offset (req_position_offset),
      .req_reverse_order   (req_reverse_order),
      .empty               (empty),
      .pop                 (pop),
      .rsp_covariate_key   (rsp_covariate_key),
      .rsp_is_mismatch     (rsp_is_mismatch),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .prdata              (prdata),
      .pready              (pready)
   );

   always #2 clock = ~clock;

   // tracked read state
   logic [3:0]  win_len = 4'd0;
   logic [7:0]  trk_prev_base = CHAR_N;
   logic [7:0]  trk_run = 8'd0;
   logic [14:0] trk_gc_hist = '0;
   logic [31:0] trk_position = 32'd0;
   logic [7:0]  trk_maxq = 8'd0;
   logic [7:0]  trk_read = 8'd0;
   logic [31:0] trk_offset = 32'd0;
   logic        trk_reversed = 1'b0;
   logic [1:0]  trk_prev_case = CASE_SAME;

   key_result_type expected_keys[$];
   key_result_type popped;
   int          errors = 0;
   int          results_seen = 0;
   int          requests_taken = 0;
   int          stall_left = 0;
   int          stall_roll = 0;
   int          cycle_count = 0;
   bit          steady = 1'b0;

   stim_row_type directed_rows [20] = '{
      '{'{CMD_BASE, CHAR_A, 8'd0, CASE_SAME, CASE_SAME, 8'd0, 32'd0, 1'b0}, 1'b1,
        '{{32'd0, 6'd0, 5'd20, 4'd0, 5'd0, 6'd0, 6'd0}, 1'b0}},
      '{'{CMD_UNUSED, 8'hFF, 8'hFF, CASE_RESERVED, CASE_RESERVED, 8'hFF, 32'hFFFF_FFFF,
          1'b1}, 1'b0, NO_RESULT},
      '{'{CMD_START, 8'd0, 8'd0, CASE_SAME, CASE_SAME, 8'hFF, 32'hFFFF_FFFF, 1'b0},
        1'b0, NO_RESULT},
      '{'{CMD_SCAN, 8'd0, 8'hFF, CASE_SAME, CASE_SAME, 8'd0, 32'd0, 1'b0}, 1'b0, NO_RESULT},
      '{'{CMD_SCAN, 8'd0, 8'd7, CASE_SAME, CASE_SAME, 8'd0, 32'd0, 1'b0}, 1'b0, NO_RESULT},
      '{'{CMD_BASE, CHAR_G, 8'hFF, CASE_DIFF, CASE_DIFF, 8'd0, 32'd0, 1'b0}, 1'b1,
        '{{32'hFFFF_FFFF, 6'd63, 5'd22, 4'd0, 5'd0, 6'd63, 6'd63}, 1'b1}},
      '{'{CMD_BASE, CHAR_G, 8'd0, CASE_SAME, CASE_SAME, 8'd0, 32'd0, 1'b0}, 1'b1,
        '{{32'd0, 6'd63, 5'd12, 4'd0, 5'd1, 6'd63, 6'd0}, 1'b0}},
      '{'{CMD_BASE, CHAR_G | 8'h20, 8'd30, CASE_SKIP, CASE_SAME, 8'd0, 32'd0, 1'b0},
        1'b0, NO_RESULT},
      '{'{CMD_BASE, CHAR_C, 8'd40, CASE_SAME, CASE_SKIP, 8'd0, 32'd0, 1'b0}, 1'b0, NO_RESULT},
      '{'{CMD_BASE, CHAR_T, 8'd9, CASE_SAME, CASE_RESERVED, 8'd0, 32'd0, 1'b0},
        1'b0, NO_RESULT},
      '{'{CMD_BASE, CHAR_T, 8'd200, CASE_RESERVED, CASE_SAME, 8'd0, 32'd0, 1'b0},
        1'b0, NO_RESULT},
      '{'{CMD_START, 8'd0, 8'd0, CASE_SAME, CASE_SAME, 8'd5, 32'h1234_5678, 1'b1},
        1'b0, NO_RESULT},
      '{'{CMD_SCAN, 8'd0, 8'd0, CASE_SAME, CASE_SAME, 8'd0, 32'd0, 1'b0}, 1'b0, NO_RESULT},
      '{'{CMD_BASE, CHAR_C, 8'd12, CASE_DIFF, CASE_SKIP, 8'd0, 32'd0, 1'b0},
        1'b0, NO_RESULT},
      '{'{CMD_BASE, CHAR_C, 8'd63, CASE_SAME, CASE_SAME, 8'd0, 32'd0, 1'b0}, 1'b0, NO_RESULT},
      '{'{CMD_BASE, CHAR_A, 8'd64, CASE_RESERVED, CASE_SAME, 8'd0, 32'd0, 1'b0},
        1'b0, NO_RESULT},
      '{'{CMD_BASE, CHAR_A, 8'd1, CASE_SAME, CASE_SAME, 8'd0, 32'd0, 1'b0}, 1'b0, NO_RESULT},
      '{'{CMD_BASE, 8'h00, 8'd2, CASE_SAME, CASE_SAME, 8'd0, 32'd0, 1'b0}, 1'b0, NO_RESULT},
      '{'{CMD_BASE, 8'hFF, 8'd128, CASE_DIFF, CASE_DIFF, 8'd0, 32'd0, 1'b0},
        1'b0, NO_RESULT},
      '{'{CMD_START, 8'd0, 8'd0, CASE_SAME, CASE_SAME, 8'd0, 32'd0, 1'b0}, 1'b0, NO_RESULT}
   };

   int window_plan [8] = '{15, 0, 7, 15, 3, 0, 9, 1};

   function automatic int level_cap(input int value, input int levels);
      return (value >= levels) ? levels - 1 : value;
   endfunction

   function automatic int letter_code(input logic [7:0] ch);
      if (ch == CHAR_A) return 0;
      if (ch == CHAR_C) return 1;
      if (ch == CHAR_G) return 2;
      if (ch == CHAR_T) return 3;
      return 4;
   endfunction

   task automatic clear_read_history();
      trk_prev_base = CHAR_N;
      trk_run       = 8'd0;
      trk_gc_hist   = '0;
      trk_position  = 32'd0;
      trk_maxq      = 8'd0;
      trk_prev_case = CASE_SAME;
   endtask

   task automatic predict_key(input base_request_type r, output bit made,
                              output key_result_type res);
      int         span;
      int         gc;
      int         dimer;
      logic [1:0] counted;
      made = 1'b0;
      res  = NO_RESULT;
      case (r.cmd)
         CMD_START: begin
            clear_read_history();
            trk_read     = r.read_number;
            trk_offset   = r.position_offset;
            trk_reversed = r.reverse_order;
         end
         CMD_SCAN: begin
            if (r.quality > trk_maxq) trk_maxq = r.quality;
         end
         CMD_BASE: begin
            if (r.base_char == trk_prev_base) begin
               if (trk_run != 8'hFF) trk_run = trk_run + 8'd1;
            end else begin
               trk_run = 8'd0;
            end
            span = level_cap(int'(win_len), DEF_GC_LEVELS);
            gc = 0;
            for (int i = 0; i < 15; i++) begin
               if (i < span && trk_gc_hist[i]) gc++;
            end
            counted = trk_reversed ? trk_prev_case : r.case_next;
            if (r.case_here != CASE_SKIP && r.case_next != CASE_SKIP &&
                (counted == CASE_SAME || counted == CASE_DIFF)) begin
               dimer = 5 * letter_code(trk_prev_base) + letter_code(r.base_char);
               res.key = {trk_position + trk_offset,
                          6'(level_cap(int'(trk_read), DEF_READ_LEVELS)),
                          5'(level_cap(dimer, DEF_DIMER_LEVELS)),
                          4'(level_cap(gc, DEF_GC_LEVELS)),
                          5'(level_cap(int'(trk_run), DEF_RUN_LEVELS)),
                          6'(level_cap(int'(trk_maxq), DEF_MAXQ_LEVELS)),
                          6'(level_cap(int'(r.quality), DEF_QUAL_LEVELS))};
               res.mismatch = (counted == CASE_DIFF);
               made = 1'b1;
            end
            trk_gc_hist   = {trk_gc_hist[13:0],
                             (r.base_char == CHAR_G || r.base_char == CHAR_C)};
            trk_prev_case = r.case_here;
            trk_prev_base = r.base_char;
            trk_position  = trk_position + 32'd1;
         end
         default: ;
      endcase
   endtask

   task automatic issue(input base_request_type r, input bit known,
                        input key_result_type want);
      bit             made;
      key_result_type got;
      int             roll;
      int             gap;
      push                <= 1'b1;
      req_cmd             <= r.cmd;
      req_base_char       <= r.base_char;
      req_quality         <= r.quality;
      req_case_here       <= r.case_here;
      req_case_next       <= r.case_next;
      req_read_number     <= r.read_number;
      req_position_offset <= r.position_offset;
      req_reverse_order   <= r.reverse_order;
      do @(posedge clock); while (full);
      predict_key(r, made, got);
      if (known) expected_keys.push_back(want);
      else if (made) expected_keys.push_back(got);
      if (r.cmd != CMD_UNUSED) requests_taken++;
      roll = $urandom_range(0, 99);
      gap  = 0;
      if (!steady) begin
         if (roll >= 96) gap = $urandom_range(10, 40);
         else if (roll >= 65) gap = $urandom_range(1, 3);
      end
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      push <= 1'b0;
      while (expected_keys.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_window(input logic [3:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_W'(4 * int'(REG_GC_WINDOW_LEN));
      pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      win_len = value;
   endtask

   function automatic base_request_type random_request();
      base_request_type r;
      r.cmd             = 2'($urandom_range(0, 3));
      r.base_char       = 8'($urandom_range(0, 255));
      r.quality         = 8'($urandom_range(0, 255));
      r.case_here       = 2'($urandom_range(0, 3));
      r.case_next       = 2'($urandom_range(0, 3));
      r.read_number     = 8'($urandom_range(0, 255));
      r.position_offset = $urandom();
      r.reverse_order   = 1'($urandom_range(0, 1));
      return r;
   endfunction

   function automatic logic [1:0] pick_case();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return CASE_SAME;
      if (roll < 85) return CASE_DIFF;
      if (roll < 96) return CASE_SKIP;
      return CASE_RESERVED;
   endfunction

   function automatic logic [7:0] pick_letter(input logic [7:0] last);
      logic [7:0] letters [5];
      int         roll;
      letters = '{CHAR_A, CHAR_C, CHAR_G, CHAR_T, CHAR_N};
      roll = $urandom_range(0, 99);
      if (roll < 30) return last;
      if (roll < 82) return letters[$urandom_range(0, 4)];
      if (roll < 92) return letters[$urandom_range(0, 4)] | 8'h20;
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic random_read(input bit homopolymer, input bit with_start);
      base_request_type r;
      logic [7:0]       last;
      int               n_base;
      if (with_start) begin
         r = random_request();
         r.cmd = CMD_START;
         issue(r, 1'b0, NO_RESULT);
         repeat ($urandom_range(0, 4)) begin
            r = random_request();
            r.cmd = CMD_SCAN;
            if ($urandom_range(0, 3) == 0) r.quality = 8'($urandom_range(0, 70));
            issue(r, 1'b0, NO_RESULT);
         end
      end
      n_base = homopolymer ? $urandom_range(260, 300) : $urandom_range(1, 24);
      last = CHAR_N;
      repeat (n_base) begin
         r = random_request();
         r.cmd       = CMD_BASE;
         r.base_char = homopolymer ? CHAR_A : pick_letter(last);
         r.case_here = pick_case();
         r.case_next = pick_case();
         last = r.base_char;
         issue(r, 1'b0, NO_RESULT);
      end
   endtask

   // result side: random stalls outside steady phases, compare against the oldest expectation
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            results_seen++;
            if (expected_keys.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("unexpected result %0d: key %h mismatch %b", results_seen,
                           rsp_covariate_key, rsp_is_mismatch);
            end else begin
               popped = expected_keys.pop_front();
               if (rsp_covariate_key !== popped.key ||
                   rsp_is_mismatch !== popped.mismatch) begin
                  errors++;
                  if (errors <= 10)
                     $display("result %0d: expected key %h mismatch %b, got key %h mismatch %b",
                              results_seen, popped.key, popped.mismatch,
                              rsp_covariate_key, rsp_is_mismatch);
               end
            end
         end
         if (stall_left > 0) begin
            pop <= 1'b0;
            stall_left--;
         end else begin
            pop <= 1'b1;
            if (!steady) begin
               stall_roll = $urandom_range(0, 99);
               if (stall_roll < 15) stall_left = $urandom_range(1, 3);
               else if (stall_roll < 18) stall_left = $urandom_range(10, 40);
               else stall_left = 0;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      int         phase;
      int         stop_at;
      logic [3:0] setting;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         issue(directed_rows[i].req, directed_rows[i].known, directed_rows[i].want);

      phase = 0;
      while (requests_taken < ITEM_TARGET) begin
         drain();
         setting = (phase < 8) ? 4'(window_plan[phase]) : 4'($urandom_range(0, 15));
         write_window(setting);
         steady = (phase % 3 == 1);
         stop_at = requests_taken + 160;
         // carry on with the read from the previous phase under the new window
         if (phase % 2 == 1) random_read(1'b0, 1'b0);
         if (phase == 2 || phase == 5) random_read(1'b1, 1'b1);
         while (requests_taken < stop_at) begin
            if ($urandom_range(0, 9) == 0) issue(random_request(), 1'b0, NO_RESULT);
            else random_read(1'b0, 1'b1);
         end
         phase++;
      end
      drain();

      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
